/* sv/efws_pkg.sv */
// ---------------------------------------------------------------------------
// efws_pkg
// Shared widths, constants and the result type of the earliest-free worker
// scheduler.
// ---------------------------------------------------------------------------
package efws_pkg;

    // Field widths
    localparam int TIME_W = 63;
    localparam int DUR_W  = 31;
    localparam int WIDX_W = 8;
    localparam int CFG_W  = 9;

    // Largest free time; sums above it saturate here
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // One result: the worker taken and the job's start time
    typedef struct packed {
        logic [WIDX_W-1:0] worker_index;
        logic [TIME_W-1:0] start_time;
    } res_t;

endpackage

/* sv/efws_ram.sv */
// ---------------------------------------------------------------------------
// efws_ram
// Heap store: one write port, two read ports, read data registered.
// ---------------------------------------------------------------------------
module efws_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 71
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* sv/efws_ctrl.sv */
// ---------------------------------------------------------------------------
// efws_ctrl
// Sequencer: clearing sweep, request intake with root read-out, and the
// sift-down walk with one heap level per cycle.
// ---------------------------------------------------------------------------
module efws_ctrl #(
    parameter int MAX_WORKERS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Heap size and re-initialise request
    input  logic [$clog2(MAX_WORKERS+1)-1:0]   count,
    input  logic                               init_req,
    // Request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [efws_pkg::DUR_W-1:0]         dur,
    // Result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output efws_pkg::res_t                     out_res,
    // Heap store
    output logic                               wr_en,
    output logic [$clog2(MAX_WORKERS)-1:0]     wr_addr,
    output logic [efws_pkg::TIME_W+$clog2(MAX_WORKERS)-1:0] wr_data,
    output logic [$clog2(MAX_WORKERS)-1:0]     rd_addr_a,
    output logic [$clog2(MAX_WORKERS)-1:0]     rd_addr_b,
    input  logic [efws_pkg::TIME_W+$clog2(MAX_WORKERS)-1:0] rd_data_a,
    input  logic [efws_pkg::TIME_W+$clog2(MAX_WORKERS)-1:0] rd_data_b
);

    import efws_pkg::*;

    localparam int PW    = $clog2(MAX_WORKERS);
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam int CW    = PW + 2;
    localparam int ENT_W = TIME_W + PW;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SIFT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   sweep_idx_reg;
    logic [PW-1:0]      pos_reg;
    logic [ENT_W-1:0]   cur_reg;
    logic               lval_reg;
    logic               rval_reg;
    logic [ENT_W-1:0]   top_reg;
    logic               out_valid_reg;
    res_t               out_res_reg;

    logic               accept;
    logic               sweep_last;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  new_time;
    logic [CW-1:0]      n_ext;
    logic [CW-1:0]      l_idx;
    logic               pick_r;
    logic [ENT_W-1:0]   ch_ent;
    logic [PW-1:0]      ch_pos;
    logic               go_down;
    logic [PW-1:0]      base_idx;
    logic [CW-1:0]      nl_idx;
    logic [CW-1:0]      nr_idx;

    // Handshake
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign sweep_last = (CNT_W'(sweep_idx_reg + 1'b1) == count);

    // Saturating add of the duration onto the root's free time
    assign sum      = {1'b0, top_reg[ENT_W-1:PW]} + (TIME_W+1)'(dur);
    assign new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    // Pick the smaller child; entries order as {free time, worker}
    assign n_ext   = CW'(count);
    assign l_idx   = CW'({pos_reg, 1'b1});
    assign pick_r  = rval_reg && (rd_data_b < rd_data_a);
    assign ch_ent  = pick_r ? rd_data_b : rd_data_a;
    assign ch_pos  = pick_r ? PW'(l_idx + 1'b1) : PW'(l_idx);
    assign go_down = lval_reg && (ch_ent < cur_reg);

    // Children of the slot handled next: root on intake, chosen child in a walk
    assign base_idx  = (state_reg == ST_SIFT) ? ch_pos : '0;
    assign nl_idx    = CW'({base_idx, 1'b1});
    assign nr_idx    = nl_idx + 1'b1;
    assign rd_addr_a = nl_idx[PW-1:0];
    assign rd_addr_b = nr_idx[PW-1:0];

    // Store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_idx_reg[PW-1:0];
                wr_data = {{TIME_W{1'b0}}, sweep_idx_reg[PW-1:0]};
            end
            ST_SIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = go_down ? ch_ent : cur_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_idx_reg <= '0;
            pos_reg       <= '0;
            lval_reg      <= 1'b0;
            rval_reg      <= 1'b0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result register
            if (accept)
            begin
                out_valid_reg            <= 1'b1;
                out_res_reg.worker_index <= WIDX_W'(top_reg[PW-1:0]);
                out_res_reg.start_time   <= top_reg[ENT_W-1:PW];
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (init_req)
            begin
                state_reg     <= ST_INIT;
                sweep_idx_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    ST_INIT:
                    begin
                        top_reg       <= '0;
                        sweep_idx_reg <= CNT_W'(sweep_idx_reg + 1'b1);
                        if (sweep_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (accept)
                        begin
                            cur_reg   <= {new_time, top_reg[PW-1:0]};
                            pos_reg   <= '0;
                            lval_reg  <= (nl_idx < n_ext);
                            rval_reg  <= (nr_idx < n_ext);
                            state_reg <= ST_SIFT;
                        end
                    end
                    ST_SIFT:
                    begin
                        // root copy follows every write to slot 0
                        if (pos_reg == '0)
                        begin
                            top_reg <= wr_data;
                        end
                        if (go_down)
                        begin
                            pos_reg  <= ch_pos;
                            lval_reg <= (nl_idx < n_ext);
                            rval_reg <= (nr_idx < n_ext);
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

/* sv/earliest_free_worker_scheduler.sv */
// ---------------------------------------------------------------------------
// earliest_free_worker_scheduler
// Min-heap of workers keyed by next free time; each job request goes to the
// earliest free worker, lower index winning ties.
//
//   channel        signals                          dir  moves
//   request        in_valid / in_ready              in   job_duration
//   result         out_valid / out_ready            out  worker_index, start_time
//   configuration  thread_count_we                  in   thread_count
//
// A request is taken in the idle state, then the sift-down walks the heap, its
// pace set by the store's registered read: one level per cycle.
// After reset, and after each thread_count write, a sweep writes one heap slot
// per cycle up to the clamped worker count; no request is taken meanwhile.
// A request is taken while a result waits if that result leaves the same cycle.
// ---------------------------------------------------------------------------
module earliest_free_worker_scheduler #(
    parameter int MAX_WORKERS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          thread_count_we,
    input  logic [efws_pkg::CFG_W-1:0]    thread_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [efws_pkg::DUR_W-1:0]    job_duration,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [efws_pkg::WIDX_W-1:0]   worker_index,
    output logic [efws_pkg::TIME_W-1:0]   start_time
);

    import efws_pkg::*;

    localparam int PW      = $clog2(MAX_WORKERS);
    localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
    localparam int ENT_W   = TIME_W + PW;
    localparam int CNT_RST = (256 > MAX_WORKERS) ? MAX_WORKERS : 256;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    res_t             res;
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [PW-1:0]    rd_addr_a;
    logic [PW-1:0]    rd_addr_b;
    logic [ENT_W-1:0] rd_data_a;
    logic [ENT_W-1:0] rd_data_b;

    // Worker count, clamped to 1..MAX_WORKERS
    always_comb
    begin
        if (thread_count == '0)
        begin
            count_next = CNT_W'(1);
        end
        else if (32'(thread_count) > MAX_WORKERS)
        begin
            count_next = CNT_W'(MAX_WORKERS);
        end
        else
        begin
            count_next = CNT_W'(thread_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(CNT_RST);
        end
        else if (thread_count_we)
        begin
            count_reg <= count_next;
        end
    end

    efws_ctrl #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .count     (count_reg),
        .init_req  (thread_count_we),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dur       (job_duration),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    efws_ram #(
        .DEPTH (MAX_WORKERS),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Result fields
    assign worker_index = res.worker_index;
    assign start_time   = res.start_time;

endmodule

/* sv/efws_checker.sv */
// ---------------------------------------------------------------------------
// efws_checker
// Port-level checks on the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
module efws_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          thread_count_we,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [efws_pkg::WIDX_W-1:0]   worker_index,
    input  logic [efws_pkg::TIME_W-1:0]   start_time
);

    // A waiting result holds still
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(worker_index)
                                    && $stable(start_time))
        else $error("result changed while stalled");

    // Every taken request gives a result on the next cycle
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after request");

    // The heap walk blocks intake in the cycle after a taken request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken during heap walk");

    // Re-initialisation sweep blocks intake
    a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        thread_count_we |=> !in_ready)
        else $error("request taken during sweep");

endmodule

bind earliest_free_worker_scheduler efws_checker u_chk (.*);

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the earliest-free worker scheduler. Job requests are
// queued by a stimulus sequence and driven on the falling edge. Each accepted
// request is run through a local min-heap model. Every result is compared,
// field by field, with the oldest predicted assignment. Worker counts are
// rewritten between phases, and idling on each side changes with the phase.
// ---------------------------------------------------------------------------
module tb;

    import efws_pkg::*;

    localparam int NUM_WORKERS   = 256;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_JOBS    = 80;
    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               thread_count_we;
    logic [CFG_W-1:0]   thread_count;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [DUR_W-1:0]   job_duration = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [WIDX_W-1:0]  worker_index;
    logic [TIME_W-1:0]  start_time;

    // Model of the heap
    logic [WIDX_W-1:0]  slot_worker [NUM_WORKERS];
    logic [TIME_W-1:0]  slot_free   [NUM_WORKERS];
    int                 active_workers;

    logic [DUR_W-1:0]   pending_jobs [$];
    res_t               predicted_assignments [$];
    int                 jobs_queued;
    int                 jobs_taken = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 job_taken = 1'b0;

    earliest_free_worker_scheduler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .thread_count_we (thread_count_we),
        .thread_count    (thread_count),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .job_duration    (job_duration),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .worker_index    (worker_index),
        .start_time      (start_time)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Clamp the count and put worker k in slot k, all free at time zero
    function automatic void load_workers(input logic [CFG_W-1:0] count);
        active_workers = (count == 0) ? 1 : ((count > NUM_WORKERS) ? NUM_WORKERS : count);
        for (int k = 0; k < NUM_WORKERS; k++)
        begin
            slot_worker[k] = k[WIDX_W-1:0];
            slot_free[k]   = '0;
        end
    endfunction

    // Slot a orders strictly before slot b: free time first, then worker
    function automatic bit earlier_slot(input int a, input int b);
        if (slot_free[a] != slot_free[b])
            return slot_free[a] < slot_free[b];
        return slot_worker[a] < slot_worker[b];
    endfunction

    // Hand the job to the root worker, bump its free time, sift it down
    function automatic res_t schedule_job(input logic [DUR_W-1:0] dur);
        res_t              taken;
        logic [TIME_W:0]   sum;
        logic [WIDX_W-1:0] tmp_worker;
        logic [TIME_W-1:0] tmp_free;
        int                pos;
        int                best;
        taken.worker_index = slot_worker[0];
        taken.start_time   = slot_free[0];
        sum = {1'b0, slot_free[0]} + dur;
        slot_free[0] = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
        pos = 0;
        forever
        begin
            best = pos;
            if (2 * pos + 1 < active_workers && earlier_slot(2 * pos + 1, best))
                best = 2 * pos + 1;
            if (2 * pos + 2 < active_workers && earlier_slot(2 * pos + 2, best))
                best = 2 * pos + 2;
            if (best == pos)
                break;
            tmp_worker        = slot_worker[pos];
            tmp_free          = slot_free[pos];
            slot_worker[pos]  = slot_worker[best];
            slot_free[pos]    = slot_free[best];
            slot_worker[best] = tmp_worker;
            slot_free[best]   = tmp_free;
            pos = best;
        end
        return taken;
    endfunction

    // Mix of ties, small and full-range durations
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(7))
            0:       return '0;
            1:       return DUR_MAX;
            2, 3:    return DUR_W'($urandom_range(3));
            4:       return DUR_W'($urandom_range(255));
            default: return DUR_W'($urandom) & DUR_MAX;
        endcase
    endfunction

    task automatic queue_job(input logic [DUR_W-1:0] dur);
        pending_jobs.push_back(dur);
        jobs_queued++;
    endtask

    // Wait until every request is taken and every result is back, then settle
    task automatic drain();
        while (jobs_taken != jobs_queued || predicted_assignments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] count);
        @(negedge clk);
        thread_count_we <= 1'b1;
        thread_count    <= count;
        load_workers(count);
        @(negedge clk);
        thread_count_we <= 1'b0;
    endtask

    // Request driver and result-side stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (!in_valid || job_taken)
        begin
            if (pending_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid     <= 1'b1;
                job_duration <= pending_jobs.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check results, then predict for newly accepted requests
    always @(posedge clk)
    begin
        res_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("earliest_free_worker_scheduler verification failed");
            $finish;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_assignments.size() == 0)
                begin
                    $error("unexpected result: worker_index %0d start_time %0d",
                           worker_index, start_time);
                    fail_count++;
                end
                else
                begin
                    want = predicted_assignments.pop_front();
                    if (worker_index !== want.worker_index)
                    begin
                        $error("worker_index: expected %0d, got %0d",
                               want.worker_index, worker_index);
                        fail_count++;
                    end
                    if (start_time !== want.start_time)
                    begin
                        $error("start_time: expected %0d, got %0d",
                               want.start_time, start_time);
                        fail_count++;
                    end
                end
            end
            job_taken = in_valid && in_ready;
            if (job_taken)
            begin
                predicted_assignments.push_back(schedule_job(job_duration));
                jobs_taken++;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int phase_counts [RAND_PHASES];
        int send_pcts    [4];
        int stall_pcts   [4];
        phase_counts = '{256, 1, 2, 3, 7, 100, 255, 511, 300, 5};
        send_pcts    = '{0, 69, 0, 25};
        stall_pcts   = '{0, 0, 69, 25};
        rst_n           = 1'b0;
        thread_count_we = 1'b0;
        thread_count    = '0;
        jobs_queued     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        load_workers(CFG_W'(NUM_WORKERS));
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset count: extremes of the duration, early ties at time zero
        foreach (send_pcts[i])
            queue_job(i[0] ? DUR_MAX : '0);
        queue_job(DUR_W'(1));
        queue_job(DUR_MAX);
        queue_job(DUR_W'(5));
        queue_job(DUR_W'(5));
        queue_job(DUR_W'('h2AAA_AAAA));
        queue_job(DUR_W'('h5555_5555));
        drain();

        // Count of zero taken as one: a single worker piles up time
        write_count('0);
        queue_job(DUR_MAX);
        queue_job(DUR_MAX);
        queue_job(DUR_MAX);
        queue_job('0);
        queue_job(DUR_W'(1));
        drain();

        // Two workers with equal free times: lower index wins
        write_count(CFG_W'(2));
        repeat (4) queue_job(DUR_W'(3));
        queue_job('0);
        queue_job('0);
        drain();

        // Count above the worker limit is clamped
        write_count('1);
        queue_job(DUR_W'(7));
        queue_job('0);
        queue_job(DUR_MAX);
        drain();

        // Random phases over several counts and idling patterns
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_count(CFG_W'(phase_counts[p]));
            send_idle_pct  = send_pcts[p % 4];
            recv_stall_pct = stall_pcts[p % 4];
            repeat (PHASE_JOBS) queue_job(pick_duration());
            drain();
        end

        if (fail_count == 0)
            $display("earliest_free_worker_scheduler verification clean");
        else
            $display("earliest_free_worker_scheduler verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/efws_pkg.sv
sv/efws_ram.sv
sv/efws_ctrl.sv
sv/earliest_free_worker_scheduler.sv
sv/efws_checker.sv
bench/tb.sv
